### rtl/core/lrmp_pkg.sv
package lrmp_pkg;

  localparam int INDEX_BITS = 63;
  localparam int VAL_W      = 30;
  localparam int SUM_W      = 62;   // four 60-bit products summed
  localparam int HI_W       = SUM_W - VAL_W;
  localparam int FOLD_W     = 27;
  localparam int FOLDP_W    = HI_W + FOLD_W;
  localparam int CFG_NUM    = 8;
  localparam int CFG_IDX_W  = 3;
  localparam int ADDR_W     = 6;

  typedef logic [VAL_W-1:0] val_t;

  localparam val_t PRIME = 30'd1000000007;
  // 2^30 mod PRIME
  localparam logic [FOLD_W-1:0] FOLD_K = 27'd73741817;

  localparam logic [CFG_IDX_W-1:0] REG_START_ZERO      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_START_ONE       = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_START_TWO       = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_OFFSET_TERM     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_BACK_THREE = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_BACK_TWO   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_BACK_ONE   = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_OFFSET     = 3'd7;

  localparam val_t CFG_RESET [CFG_NUM] = '{
    30'd1, 30'd5, 30'd9, 30'd3, 30'd1, 30'd0, 30'd1, 30'd1000000006
  };

  // matrix slots in the shared RAM
  localparam logic [1:0] MAT_ACC  = 2'd0;
  localparam logic [1:0] MAT_BASE = 2'd1;
  localparam logic [1:0] MAT_TMP  = 2'd2;

  typedef struct packed {
    logic mac_en;
    logic first;
    logic red_go;
  } mac_ctl_t;

  typedef struct packed {
    logic done;
    val_t result;
  } mac_stat_t;

  // register values are below 2*PRIME
  function automatic val_t red_mod(val_t x);
    return (x >= PRIME) ? (x - PRIME) : x;
  endfunction

endpackage

### rtl/core/lrmp_mat_ram.sv
module lrmp_mat_ram
  import lrmp_pkg::*;
(
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  val_t              wdata,
  input  logic [ADDR_W-1:0] raddr0,
  input  logic [ADDR_W-1:0] raddr1,
  output val_t              rdata0,
  output val_t              rdata1
);

  val_t mem [2**ADDR_W];
  val_t rd0_r;
  val_t rd1_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rd0_r <= mem[raddr0];
    rd1_r <= mem[raddr1];
  end

  assign rdata0 = rd0_r;
  assign rdata1 = rd1_r;

endmodule

### rtl/core/lrmp_mac_unit.sv
module lrmp_mac_unit
  import lrmp_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  mac_ctl_t  ctl,
  input  val_t      op_a,
  input  val_t      op_b,
  output mac_stat_t stat
);

  typedef enum logic [1:0] {R_IDLE, R_FOLD, R_SUB} red_state_t;

  red_state_t             state_r;
  logic [SUM_W-1:0]       sum_r;
  logic [2*VAL_W-1:0]     prod;
  logic [FOLDP_W-1:0]     fold_p;

  assign prod   = op_a * op_b;
  // hi*2^30 + lo == hi*FOLD_K + lo (mod PRIME)
  assign fold_p = sum_r[SUM_W-1:VAL_W] * FOLD_K;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= R_IDLE;
    end else begin
      unique case (state_r)
        R_IDLE: begin
          if (ctl.mac_en) begin
            sum_r <= (ctl.first ? '0 : sum_r) + SUM_W'(prod);
          end
          if (ctl.red_go) begin
            state_r <= R_FOLD;
          end
        end
        R_FOLD: begin
          if (sum_r[SUM_W-1:VAL_W+1] == '0) begin
            state_r <= R_SUB;
          end else begin
            sum_r <= SUM_W'(fold_p) + SUM_W'(sum_r[VAL_W-1:0]);
          end
        end
        R_SUB: begin
          // below 2^31, so at most two subtracts
          if (sum_r >= SUM_W'(PRIME)) begin
            sum_r <= sum_r - SUM_W'(PRIME);
          end else begin
            state_r <= R_IDLE;
          end
        end
        default: state_r <= R_IDLE;
      endcase
    end
  end

  assign stat.done   = (state_r == R_SUB) && (sum_r < SUM_W'(PRIME));
  assign stat.result = sum_r[VAL_W-1:0];

endmodule

### rtl/core/linear_recurrence_matrix_power_mod_unit.sv
// For n below 3 the result is the reduced start register; otherwise a setup pass writes the
// identity and companion matrices, then each 4x4 matrix product computes 16 entries and
// copies them back, at most two products per bit of n-2. Each matrix entry is a
// multiply-accumulate followed by modular folding on the one shared unit.
// Throughput: one request at a time; busy stays high until the result strobe.
// Reset: synchronous active-low; config registers return to their defaults.
module linear_recurrence_matrix_power_mod_unit
  import lrmp_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  logic [INDEX_BITS-1:0] in_index_n,
  output logic                  out_valid,
  output logic [VAL_W-1:0]      out_term_value,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_addr,
  input  logic [VAL_W-1:0]      cfg_wdata
);

  typedef enum logic [3:0] {
    S_IDLE, S_INIT, S_CHECK, S_ADV, S_RD, S_MAC, S_RED, S_CP_RD, S_CP_WR
  } state_t;
  typedef enum logic [1:0] {M_ACC, M_SQ, M_DOT} mode_t;

  state_t                state_r;
  mode_t                 mode_r;
  logic [3:0]            ent_r;
  logic [1:0]            m_r;
  logic [4:0]            init_r;
  logic [INDEX_BITS-1:0] e_r;
  logic                  out_valid_r;
  val_t                  out_term_r;
  val_t                  cfg_r [CFG_NUM];

  logic              we;
  logic [ADDR_W-1:0] waddr;
  val_t              wdata;
  logic [ADDR_W-1:0] raddr0;
  logic [ADDR_W-1:0] raddr1;
  val_t              rdata0;
  val_t              rdata1;
  val_t              init_val;
  val_t              vsel;
  mac_ctl_t          mac_ctl;
  mac_stat_t         mac_stat;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < CFG_NUM; i++) begin
        cfg_r[i] <= CFG_RESET[i];
      end
    end else if (cfg_we) begin
      cfg_r[cfg_addr] <= cfg_wdata;
    end
  end

  // identity into ACC, companion matrix into BASE
  always_comb begin
    init_val = '0;
    if (!init_r[4]) begin
      init_val = (init_r[3:2] == init_r[1:0]) ? val_t'(1) : '0;
    end else if (init_r[3:2] == 2'd2) begin
      init_val = red_mod(cfg_r[{1'b1, init_r[1:0]}]);
    end else if ((init_r[3:0] == 4'b0001) || (init_r[3:0] == 4'b0110) ||
                 (init_r[3:0] == 4'b1111)) begin
      init_val = val_t'(1);
    end
  end

  assign vsel = red_mod(cfg_r[{1'b0, m_r}]);

  always_comb begin
    case (mode_r)
      M_DOT:   raddr0 = {MAT_ACC, 2'd2, m_r};
      M_SQ:    raddr0 = {MAT_BASE, ent_r[3:2], m_r};
      default: raddr0 = {MAT_ACC, ent_r[3:2], m_r};
    endcase
    if (state_r == S_CP_RD) begin
      raddr0 = {MAT_TMP, ent_r};
    end
    raddr1 = {MAT_BASE, m_r, ent_r[1:0]};
  end

  always_comb begin
    we    = 1'b0;
    waddr = {MAT_TMP, ent_r};
    wdata = mac_stat.result;
    case (state_r)
      S_INIT: begin
        we    = 1'b1;
        waddr = {(init_r[4] ? MAT_BASE : MAT_ACC), init_r[3:0]};
        wdata = init_val;
      end
      S_RED: begin
        we = mac_stat.done && (mode_r != M_DOT);
      end
      S_CP_WR: begin
        we    = 1'b1;
        waddr = {((mode_r == M_ACC) ? MAT_ACC : MAT_BASE), ent_r};
        wdata = rdata0;
      end
      default: ;
    endcase
  end

  assign mac_ctl.mac_en = (state_r == S_MAC);
  assign mac_ctl.first  = (m_r == 2'd0);
  assign mac_ctl.red_go = (state_r == S_MAC) && (m_r == 2'd3);

  lrmp_mat_ram u_ram (
    .clk    (clk),
    .we     (we),
    .waddr  (waddr),
    .wdata  (wdata),
    .raddr0 (raddr0),
    .raddr1 (raddr1),
    .rdata0 (rdata0),
    .rdata1 (rdata1)
  );

  lrmp_mac_unit u_mac (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (mac_ctl),
    .op_a  (rdata0),
    .op_b  ((mode_r == M_DOT) ? vsel : rdata1),
    .stat  (mac_stat)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      mode_r      <= M_ACC;
      ent_r       <= '0;
      m_r         <= '0;
      init_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (start) begin
            if (in_index_n < INDEX_BITS'(3)) begin
              out_valid_r <= 1'b1;
              out_term_r  <= red_mod(cfg_r[{1'b0, in_index_n[1:0]}]);
            end else begin
              e_r     <= in_index_n - INDEX_BITS'(2);
              init_r  <= '0;
              state_r <= S_INIT;
            end
          end
        end
        S_INIT: begin
          init_r <= init_r + 5'd1;
          if (init_r == 5'd31) begin
            state_r <= S_CHECK;
          end
        end
        S_CHECK: begin
          ent_r <= '0;
          m_r   <= '0;
          if (e_r == '0) begin
            mode_r  <= M_DOT;
            state_r <= S_RD;
          end else if (e_r[0]) begin
            mode_r  <= M_ACC;
            state_r <= S_RD;
          end else begin
            state_r <= S_ADV;
          end
        end
        S_ADV: begin
          e_r <= e_r >> 1;
          if (e_r[INDEX_BITS-1:1] == '0) begin
            state_r <= S_CHECK;
          end else begin
            mode_r  <= M_SQ;
            ent_r   <= '0;
            m_r     <= '0;
            state_r <= S_RD;
          end
        end
        S_RD: state_r <= S_MAC;
        S_MAC: begin
          if (m_r == 2'd3) begin
            state_r <= S_RED;
          end else begin
            m_r     <= m_r + 2'd1;
            state_r <= S_RD;
          end
        end
        S_RED: begin
          if (mac_stat.done) begin
            if (mode_r == M_DOT) begin
              out_valid_r <= 1'b1;
              out_term_r  <= mac_stat.result;
              state_r     <= S_IDLE;
            end else if (ent_r == 4'd15) begin
              ent_r   <= '0;
              state_r <= S_CP_RD;
            end else begin
              ent_r   <= ent_r + 4'd1;
              m_r     <= '0;
              state_r <= S_RD;
            end
          end
        end
        S_CP_RD: state_r <= S_CP_WR;
        S_CP_WR: begin
          if (ent_r == 4'd15) begin
            ent_r   <= '0;
            state_r <= (mode_r == M_ACC) ? S_ADV : S_CHECK;
          end else begin
            ent_r   <= ent_r + 4'd1;
            state_r <= S_CP_RD;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign busy           = (state_r != S_IDLE);
  assign out_valid      = out_valid_r;
  assign out_term_value = out_term_r;

endmodule

### rtl/core/lrmp_checker.sv
module lrmp_checker
  import lrmp_pkg::*;
(
  input logic                  clk,
  input logic                  rst_n,
  input logic                  start,
  input logic                  busy,
  input logic [INDEX_BITS-1:0] in_index_n,
  input logic                  out_valid,
  input logic [VAL_W-1:0]      out_term_value
);

  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> (!busy && !out_valid))
    else $error("busy or strobe after reset");

  a_short_index: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && (in_index_n == 0 || in_index_n == 1 || in_index_n == 2))
      |=> (out_valid && !busy))
    else $error("start value not returned next cycle");

  a_long_index: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_index_n > 2) |=> (busy && !out_valid))
    else $error("long request did not go busy");

  a_residue: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_term_value < PRIME))
    else $error("result not reduced");

endmodule

bind linear_recurrence_matrix_power_mod_unit lrmp_checker u_lrmp_checker (.*);

### test/linear_recurrence_matrix_power_mod_unit_tb.sv
module linear_recurrence_matrix_power_mod_unit_tb;
  import lrmp_pkg::*;

  localparam longint unsigned MODULUS = 64'd1000000007;

  typedef longint unsigned mat4_t [4][4];

  class term_scoreboard;
    val_t pending_terms[$];
    int   mismatches;
    int   checked;

    function void note_request(val_t term);
      pending_terms.push_back(term);
    endfunction

    function void check_term(val_t actual);
      val_t want;
      if (pending_terms.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected term_value %0d with no request pending", actual);
        return;
      end
      want = pending_terms.pop_front();
      checked++;
      if (want !== actual) begin
        mismatches++;
        if (mismatches <= 10)
          $display("term_value expected %0d got %0d", want, actual);
      end
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  start = 1'b0;
  logic                  busy;
  logic [INDEX_BITS-1:0] in_index_n = '0;
  logic                  out_valid;
  logic [VAL_W-1:0]      out_term_value;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_addr = '0;
  logic [VAL_W-1:0]      cfg_wdata = '0;

  term_scoreboard sb = new();
  val_t           shadow_regs [CFG_NUM];
  bit             idle_on = 1'b1;
  int             sent;

  linear_recurrence_matrix_power_mod_unit u_dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_index_n(in_index_n), .out_valid(out_valid), .out_term_value(out_term_value),
    .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata)
  );

  always #5 clk = ~clk;

  function automatic mat4_t mat_product(mat4_t x, mat4_t y);
    mat4_t p;
    longint unsigned s;
    for (int r = 0; r < 4; r++) begin
      for (int c = 0; c < 4; c++) begin
        s = 0;
        for (int m = 0; m < 4; m++)
          s = (s + (x[r][m] * y[m][c]) % MODULUS) % MODULUS;
        p[r][c] = s;
      end
    end
    return p;
  endfunction

  function automatic val_t recurrence_term(logic [INDEX_BITS-1:0] n);
    longint unsigned seed_vec [4];
    longint unsigned e, s;
    mat4_t pw, acc;
    for (int i = 0; i < 4; i++)
      seed_vec[i] = longint'(shadow_regs[i]) % MODULUS;
    if (n < 3)
      return val_t'(seed_vec[n]);
    for (int r = 0; r < 4; r++)
      for (int c = 0; c < 4; c++) begin
        pw[r][c] = 0;
        acc[r][c] = (r == c) ? 1 : 0;
      end
    pw[0][1] = 1;
    pw[1][2] = 1;
    pw[3][3] = 1;
    for (int c = 0; c < 4; c++)
      pw[2][c] = longint'(shadow_regs[REG_COEF_BACK_THREE + c]) % MODULUS;
    e = 64'(n) - 2;
    while (e != 0) begin
      if (e[0])
        acc = mat_product(acc, pw);
      e >>= 1;
      pw = mat_product(pw, pw);
    end
    s = 0;
    for (int c = 0; c < 4; c++)
      s = (s + (acc[2][c] * seed_vec[c]) % MODULUS) % MODULUS;
    return val_t'(s);
  endfunction

  always @(posedge clk) begin
    if (rst_n && out_valid)
      sb.check_term(out_term_value);
  end

  // leaves start high; it lowers start itself only when it inserts a random idle gap
  task automatic send_request(logic [INDEX_BITS-1:0] n);
    in_index_n <= n;
    start      <= 1'b1;
    do @(posedge clk); while (busy);
    sb.note_request(recurrence_term(n));
    sent++;
    if (idle_on && $urandom_range(0, 2) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
  endtask

  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (sb.pending_terms.size() != 0)
      @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic load_all(val_t vals [CFG_NUM]);
    for (int i = 0; i < CFG_NUM; i++) begin
      cfg_we    <= 1'b1;
      cfg_addr  <= CFG_IDX_W'(i);
      cfg_wdata <= vals[i];
      @(posedge clk);
      shadow_regs[i] = vals[i];
    end
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // mostly short indices; a few reach the full width
  function automatic logic [INDEX_BITS-1:0] random_index();
    logic [INDEX_BITS-1:0] v;
    int pick;
    v = INDEX_BITS'({$urandom, $urandom});
    pick = $urandom_range(0, 99);
    if (pick < 60)      return v & 63'hF;
    else if (pick < 90) return v & 63'hFF;
    else if (pick < 98) return v & 63'hFFFF;
    return v;
  endfunction

  task automatic random_phase(int count);
    repeat (count) send_request(random_index());
    drain();
  endtask

  initial begin
    val_t vals [CFG_NUM];
    logic [INDEX_BITS-1:0] directed [$];
    for (int i = 0; i < CFG_NUM; i++)
      shadow_regs[i] = CFG_RESET[i];
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    directed = '{63'd0, 63'd1, 63'd2, 63'd3, 63'd4, 63'd5, 63'd6, 63'd7, 63'd10,
                 63'd1 << 62, {INDEX_BITS{1'b1}}, 63'h5555_5555_5555_5555,
                 63'h2AAA_AAAA_AAAA_AAAA, 63'd1025, 63'hFFFF};
    foreach (directed[i]) send_request(directed[i]);
    drain();
    random_phase(100);

    // zero, largest residue, above-range values, random residues, random raw words
    for (int setting = 0; setting < 6; setting++) begin
      for (int i = 0; i < CFG_NUM; i++) begin
        case (setting)
          0: vals[i] = '0;
          1: vals[i] = PRIME - val_t'(1);
          2: vals[i] = '1;
          3: vals[i] = PRIME;
          4: vals[i] = val_t'($urandom_range(0, 1000000006));
          default: vals[i] = val_t'($urandom);
        endcase
      end
      load_all(vals);
      if (setting == 5)
        idle_on = 1'b0;
      send_request(63'd2);
      send_request(63'd3);
      random_phase(105);
    end

    $display("covered %0d requests, %0d terms checked, over 7 register settings",
             sent, sb.checked);
    if (sb.mismatches == 0 && sb.pending_terms.size() == 0)
      $display("linear_recurrence_matrix_power_mod_unit: match");
    else
      $display("linear_recurrence_matrix_power_mod_unit: mismatch");
    $finish;
  end

  initial begin
    #2000000000;
    $display("timeout");
    $display("linear_recurrence_matrix_power_mod_unit: mismatch");
    $finish;
  end

endmodule

### sim.f
rtl/core/lrmp_pkg.sv
rtl/core/lrmp_mat_ram.sv
rtl/core/lrmp_mac_unit.sv
rtl/core/linear_recurrence_matrix_power_mod_unit.sv
rtl/core/lrmp_checker.sv
test/linear_recurrence_matrix_power_mod_unit_tb.sv
